// File: design/lcmt_pkg.sv
// Shared types and constants for the Li Chao minimum line tree.
package lcmt_pkg;

    localparam int SLOPE_W      = 32;
    localparam int ICPT_W       = 48;
    localparam int QX_W         = 12;
    localparam int MIN_W        = 49;
    localparam int X_BITS_DEF   = 12;
    localparam int ENTRY_W      = 1 + SLOPE_W + ICPT_W;
    // line value width: slope times a point of the widest domain (20 bits) plus intercept
    localparam int VAL_W        = SLOPE_W + 20 + 2;

    typedef enum logic [1:0] {
        KIND_INSERT = 2'd0,
        KIND_QUERY  = 2'd1,
        KIND_CLEAR  = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t                      kind;
        logic signed [SLOPE_W-1:0]  line_slope;
        logic signed [ICPT_W-1:0]   line_intercept;
        logic signed [QX_W-1:0]     query_x;
    } item_t;

    typedef struct packed {
        logic signed [MIN_W-1:0]    min_value;
        logic                       found;
    } result_t;

    // Control part of the token that walks the cell row.
    typedef struct packed {
        logic valid;
        logic query;
        logic done;
        logic found;
    } tok_ctl_t;

endpackage

// File: design/lcmt_ram.sv
// Generic simple dual-port RAM with registered read.
module lcmt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: design/lcmt_cell.sv
// One tree level: node store for that level plus read, multiply, add, decide steps.
module lcmt_cell #(
    parameter int X_BITS = lcmt_pkg::X_BITS_DEF,
    parameter int LEVEL  = 0
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                clr,
    input  logic [X_BITS-1:0]                   clr_addr,
    input  lcmt_pkg::tok_ctl_t                  in_ctl,
    input  logic signed [lcmt_pkg::SLOPE_W-1:0] in_slope,
    input  logic signed [lcmt_pkg::ICPT_W-1:0]  in_icpt,
    input  logic [X_BITS-1:0]                   in_lo,
    input  logic [X_BITS-1:0]                   in_hi,
    input  logic [X_BITS-1:0]                   in_u,
    input  logic [X_BITS-1:0]                   in_path,
    input  logic signed [lcmt_pkg::VAL_W-1:0]   in_best,
    output lcmt_pkg::tok_ctl_t                  out_ctl,
    output logic signed [lcmt_pkg::SLOPE_W-1:0] out_slope,
    output logic signed [lcmt_pkg::ICPT_W-1:0]  out_icpt,
    output logic [X_BITS-1:0]                   out_lo,
    output logic [X_BITS-1:0]                   out_hi,
    output logic [X_BITS-1:0]                   out_u,
    output logic [X_BITS-1:0]                   out_path,
    output logic signed [lcmt_pkg::VAL_W-1:0]   out_best
);

    localparam int ADDR_W = (LEVEL == 0) ? 1 : LEVEL;
    localparam int DEPTH  = 1 << ADDR_W;
    localparam int PROD_W = lcmt_pkg::SLOPE_W + X_BITS + 1;
    localparam int VAL_W  = lcmt_pkg::VAL_W;
    localparam logic [X_BITS:0] HALF = {2'b01, {(X_BITS-1){1'b0}}};

    // held token
    lcmt_pkg::tok_ctl_t                  t_ctl_reg;
    logic signed [lcmt_pkg::SLOPE_W-1:0] t_slope_reg;
    logic signed [lcmt_pkg::ICPT_W-1:0]  t_icpt_reg;
    logic [X_BITS-1:0]                   t_lo_reg, t_hi_reg, t_u_reg, t_path_reg;
    logic signed [VAL_W-1:0]             t_best_reg;
    logic [2:0]                          ph_reg, ph_next;

    // node data and arithmetic
    logic [lcmt_pkg::ENTRY_W-1:0]        rdata, wdata;
    logic                                we;
    logic [ADDR_W-1:0]                   waddr;
    logic                                s_valid_reg;
    logic signed [lcmt_pkg::SLOPE_W-1:0] s_slope_reg;
    logic signed [lcmt_pkg::ICPT_W-1:0]  s_icpt_reg;
    logic [X_BITS-1:0]                   m_reg;
    logic [X_BITS:0]                     lh_sum;
    logic [X_BITS-1:0]                   m_next;
    logic signed [X_BITS:0]              xm, xl, xq, xa;
    logic signed [PROD_W-1:0]            pa_reg, pb_reg, pc_reg, pd_reg;
    logic signed [VAL_W-1:0]             va_reg, vb_reg, vc_reg, vd_reg;

    // decide step
    lcmt_pkg::tok_ctl_t                  o_ctl_next;
    logic signed [lcmt_pkg::SLOPE_W-1:0] o_slope_next;
    logic signed [lcmt_pkg::ICPT_W-1:0]  o_icpt_next;
    logic [X_BITS-1:0]                   o_lo_next, o_hi_next, o_path_next;
    logic signed [VAL_W-1:0]             o_best_next;
    logic                                swap, go_left, wr_line;
    logic signed [VAL_W-1:0]             lose_l, win_l;

    lcmt_ram #(
        .WIDTH (lcmt_pkg::ENTRY_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (in_path[ADDR_W-1:0]),
        .rdata (rdata)
    );

    assign ph_next = {ph_reg[1:0], in_ctl.valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph_reg    <= '0;
            t_ctl_reg <= '0;
            out_ctl   <= '0;
        end
        else
        begin
            ph_reg <= ph_next;
            if (in_ctl.valid)
            begin
                t_ctl_reg <= in_ctl;
            end
            out_ctl <= ph_reg[2] ? o_ctl_next : '0;
        end
    end

    // midpoint and the points the lines are compared at
    always_comb
    begin
        lh_sum = {1'b0, t_lo_reg} + {1'b0, t_hi_reg};
        m_next = lh_sum[X_BITS:1];
        xm     = signed'({1'b0, m_next} - HALF);
        xl     = signed'({1'b0, t_lo_reg} - HALF);
        xq     = signed'({1'b0, t_u_reg} - HALF);
        xa     = t_ctl_reg.query ? xq : xm;
    end

    always_ff @(posedge clk)
    begin
        if (in_ctl.valid)
        begin
            t_slope_reg <= in_slope;
            t_icpt_reg  <= in_icpt;
            t_lo_reg    <= in_lo;
            t_hi_reg    <= in_hi;
            t_u_reg     <= in_u;
            t_path_reg  <= in_path;
            t_best_reg  <= in_best;
        end
        if (ph_reg[0])
        begin
            s_valid_reg <= rdata[lcmt_pkg::ENTRY_W-1];
            s_slope_reg <= signed'(rdata[lcmt_pkg::ENTRY_W-2:lcmt_pkg::ICPT_W]);
            s_icpt_reg  <= signed'(rdata[lcmt_pkg::ICPT_W-1:0]);
            m_reg       <= m_next;
            pa_reg      <= t_slope_reg * xm;
            pb_reg      <= signed'(rdata[lcmt_pkg::ENTRY_W-2:lcmt_pkg::ICPT_W]) * xa;
            pc_reg      <= t_slope_reg * xl;
            pd_reg      <= signed'(rdata[lcmt_pkg::ENTRY_W-2:lcmt_pkg::ICPT_W]) * xl;
        end
        if (ph_reg[1])
        begin
            va_reg <= VAL_W'(pa_reg) + VAL_W'(t_icpt_reg);
            vb_reg <= VAL_W'(pb_reg) + VAL_W'(s_icpt_reg);
            vc_reg <= VAL_W'(pc_reg) + VAL_W'(t_icpt_reg);
            vd_reg <= VAL_W'(pd_reg) + VAL_W'(s_icpt_reg);
        end
        if (ph_reg[2])
        begin
            out_slope <= o_slope_next;
            out_icpt  <= o_icpt_next;
            out_lo    <= o_lo_next;
            out_hi    <= o_hi_next;
            out_u     <= t_u_reg;
            out_path  <= o_path_next;
            out_best  <= o_best_next;
        end
    end

    // keep the lower line at the midpoint, route the other one
    always_comb
    begin
        o_ctl_next   = t_ctl_reg;
        o_slope_next = t_slope_reg;
        o_icpt_next  = t_icpt_reg;
        o_lo_next    = t_lo_reg;
        o_hi_next    = t_hi_reg;
        o_path_next  = t_path_reg;
        o_best_next  = t_best_reg;
        swap         = va_reg < vb_reg;
        lose_l       = swap ? vd_reg : vc_reg;
        win_l        = swap ? vc_reg : vd_reg;
        go_left      = 1'b0;
        wr_line      = 1'b0;
        if (t_ctl_reg.query)
        begin
            go_left = t_u_reg < m_reg;
            // a finished query passes deeper levels untouched
            if (s_valid_reg && !t_ctl_reg.done)
            begin
                if (!t_ctl_reg.found || vb_reg < t_best_reg)
                begin
                    o_best_next = vb_reg;
                end
                o_ctl_next.found = 1'b1;
            end
        end
        else
        begin
            go_left = lose_l < win_l;
            wr_line = !s_valid_reg || swap;
            if (swap)
            begin
                o_slope_next = s_slope_reg;
                o_icpt_next  = s_icpt_reg;
            end
        end
        if (!t_ctl_reg.done)
        begin
            if (t_ctl_reg.query && t_u_reg == m_reg)
            begin
                o_ctl_next.done = 1'b1;
            end
            else if (!t_ctl_reg.query && !s_valid_reg)
            begin
                o_ctl_next.done = 1'b1;
            end
            else if (go_left)
            begin
                o_ctl_next.done = m_reg == t_lo_reg;
                o_hi_next       = m_reg - 1'b1;
            end
            else
            begin
                o_ctl_next.done = m_reg == t_hi_reg;
                o_lo_next       = m_reg + 1'b1;
            end
            o_path_next = {t_path_reg[X_BITS-2:0], !go_left};
        end
        else
        begin
            wr_line = 1'b0;
        end
        if (t_ctl_reg.query)
        begin
            wr_line = 1'b0;
        end
    end

    always_comb
    begin
        we    = clr || (ph_reg[2] && wr_line);
        waddr = clr ? clr_addr[ADDR_W-1:0] : t_path_reg[ADDR_W-1:0];
        wdata = clr ? '0 : {1'b1, t_slope_reg, t_icpt_reg};
    end

endmodule

// File: design/li_chao_min_line_tree_unit.sv
// Top level of the Li Chao minimum line tree: item intake, cell row, clear sweep, result buffer.
//
// Usage:
//   item channel (item_valid / item_stall / item) takes one transfer per item:
//   insert a line, query the minimum at a point, or clear all lines. A kind
//   code of 3 is taken and dropped.
//   result channel (result_valid / result_stall / result) carries one transfer
//   per query: min_value and found (found low and min_value zero when empty).
//   The tree is a row of X_BITS+1 cells, one per tree level, each with its own
//   node memory. A token walks the row; each cell takes it through read,
//   multiply, add, compare and write back, and one item is in the row at a
//   time, so a new item is taken only once the last has left the row.
//   A clear sweeps all node memories, one address per cycle. The same sweep
//   runs right after reset; item_stall stays high meanwhile.
//   Results land in an output register with one spare slot behind it, so a
//   new item is taken while a result still waits; item_stall rises only when
//   both slots could be full, besides while an item walks the row or a sweep runs.
module li_chao_min_line_tree_unit #(
    parameter int X_BITS = lcmt_pkg::X_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  lcmt_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_stall,
    output lcmt_pkg::result_t result
);

    localparam int NCELL = X_BITS + 1;
    localparam int VAL_W = lcmt_pkg::VAL_W;
    localparam int XE_W  = ((X_BITS > lcmt_pkg::QX_W) ? X_BITS : lcmt_pkg::QX_W) + 2;
    localparam logic signed [XE_W-1:0] HALF_E = XE_W'(1) << (X_BITS - 1);
    localparam logic signed [XE_W-1:0] UMAX_E = (XE_W'(1) << X_BITS) - XE_W'(1);

    // chain wiring between cells
    lcmt_pkg::tok_ctl_t                  ch_ctl   [NCELL+1];
    logic signed [lcmt_pkg::SLOPE_W-1:0] ch_slope [NCELL+1];
    logic signed [lcmt_pkg::ICPT_W-1:0]  ch_icpt  [NCELL+1];
    logic [X_BITS-1:0]                   ch_lo    [NCELL+1];
    logic [X_BITS-1:0]                   ch_hi    [NCELL+1];
    logic [X_BITS-1:0]                   ch_u     [NCELL+1];
    logic [X_BITS-1:0]                   ch_path  [NCELL+1];
    logic signed [VAL_W-1:0]             ch_best  [NCELL+1];

    logic                     busy_reg, busy_next;
    logic                     sweep_reg, sweep_next;
    logic [X_BITS-1:0]        sweep_cnt_reg, sweep_cnt_next;
    lcmt_pkg::tok_ctl_t       start_ctl_reg;
    logic signed [lcmt_pkg::SLOPE_W-1:0] start_slope_reg;
    logic signed [lcmt_pkg::ICPT_W-1:0]  start_icpt_reg;
    logic [X_BITS-1:0]        start_u_reg;
    logic                     res_valid_reg, hold_valid_reg;
    lcmt_pkg::result_t        res_reg, hold_reg, new_res;
    logic                     accept, start, new_valid, out_xfer;
    logic signed [XE_W-1:0]   u_full;
    logic [X_BITS-1:0]        u_sat;

    assign item_stall   = busy_reg || sweep_reg || hold_valid_reg;
    assign accept       = item_valid && !item_stall;
    assign result_valid = res_valid_reg;
    assign result       = res_reg;
    assign out_xfer     = res_valid_reg && !result_stall;

    // map the query point into the domain, saturating at both ends
    always_comb
    begin
        u_full = XE_W'(item.query_x) + HALF_E;
        if (u_full < 0)
        begin
            u_sat = '0;
        end
        else if (u_full > UMAX_E)
        begin
            u_sat = '1;
        end
        else
        begin
            u_sat = u_full[X_BITS-1:0];
        end
    end

    always_comb
    begin
        start          = 1'b0;
        busy_next      = busy_reg;
        sweep_next     = sweep_reg;
        sweep_cnt_next = sweep_cnt_reg;
        if (sweep_reg)
        begin
            sweep_cnt_next = sweep_cnt_reg + 1'b1;
            if (sweep_cnt_reg == '1)
            begin
                sweep_next = 1'b0;
            end
        end
        if (ch_ctl[NCELL].valid)
        begin
            busy_next = 1'b0;
        end
        if (accept)
        begin
            unique case (item.kind)
                lcmt_pkg::KIND_INSERT, lcmt_pkg::KIND_QUERY:
                begin
                    start     = 1'b1;
                    busy_next = 1'b1;
                end
                lcmt_pkg::KIND_CLEAR:
                begin
                    sweep_next     = 1'b1;
                    sweep_cnt_next = '0;
                end
                default:
                begin
                    start = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            sweep_reg     <= 1'b1;
            sweep_cnt_reg <= '0;
            start_ctl_reg <= '0;
        end
        else
        begin
            busy_reg      <= busy_next;
            sweep_reg     <= sweep_next;
            sweep_cnt_reg <= sweep_cnt_next;
            start_ctl_reg <= '{valid: start,
                               query: item.kind == lcmt_pkg::KIND_QUERY,
                               done: 1'b0,
                               found: 1'b0};
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            start_slope_reg <= item.line_slope;
            start_icpt_reg  <= item.line_intercept;
            start_u_reg     <= u_sat;
        end
    end

    assign ch_ctl[0]   = start_ctl_reg;
    assign ch_slope[0] = start_slope_reg;
    assign ch_icpt[0]  = start_icpt_reg;
    assign ch_lo[0]    = '0;
    assign ch_hi[0]    = '1;
    assign ch_u[0]     = start_u_reg;
    assign ch_path[0]  = '0;
    assign ch_best[0]  = '0;

    for (genvar k = 0; k < NCELL; k++)
    begin : g_cell
        lcmt_cell #(
            .X_BITS (X_BITS),
            .LEVEL  (k)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .clr       (sweep_reg),
            .clr_addr  (sweep_cnt_reg),
            .in_ctl    (ch_ctl[k]),
            .in_slope  (ch_slope[k]),
            .in_icpt   (ch_icpt[k]),
            .in_lo     (ch_lo[k]),
            .in_hi     (ch_hi[k]),
            .in_u      (ch_u[k]),
            .in_path   (ch_path[k]),
            .in_best   (ch_best[k]),
            .out_ctl   (ch_ctl[k+1]),
            .out_slope (ch_slope[k+1]),
            .out_icpt  (ch_icpt[k+1]),
            .out_lo    (ch_lo[k+1]),
            .out_hi    (ch_hi[k+1]),
            .out_u     (ch_u[k+1]),
            .out_path  (ch_path[k+1]),
            .out_best  (ch_best[k+1])
        );
    end

    // result from the end of the row; spare slot catches it while the output is stalled
    assign new_valid = ch_ctl[NCELL].valid && ch_ctl[NCELL].query;
    assign new_res   = '{min_value: ch_best[NCELL][lcmt_pkg::MIN_W-1:0],
                         found: ch_ctl[NCELL].found};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg  <= 1'b0;
            hold_valid_reg <= 1'b0;
        end
        else if (!res_valid_reg || out_xfer)
        begin
            if (hold_valid_reg)
            begin
                res_valid_reg  <= 1'b1;
                hold_valid_reg <= new_valid;
            end
            else
            begin
                res_valid_reg <= new_valid;
            end
        end
        else if (new_valid)
        begin
            hold_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!res_valid_reg || out_xfer)
        begin
            if (hold_valid_reg)
            begin
                res_reg <= hold_reg;
                if (new_valid)
                begin
                    hold_reg <= new_res;
                end
            end
            else if (new_valid)
            begin
                res_reg <= new_res;
            end
        end
        else if (new_valid)
        begin
            hold_reg <= new_res;
        end
    end

endmodule

// File: bench/tb_li_chao_min_line_tree_unit.sv
// Testbench for the Li Chao minimum line tree: random and directed items checked against a predictor.
`timescale 1ns / 100ps

module tb_li_chao_min_line_tree_unit;
    import lcmt_pkg::*;

    localparam int DOM      = 1 << X_BITS_DEF;
    localparam int HALF     = DOM / 2;
    localparam int WD_LIMIT = 20000;   // covers the clear sweep several times over
    localparam int LONG_HOLD = 400;    // receiver hold-off, well past the row latency

    logic    clk;
    logic    rst_n;
    logic    item_valid;
    logic    item_stall;
    item_t   item;
    logic    result_valid;
    logic    result_stall;
    result_t result;

    li_chao_min_line_tree_unit u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    // Own copy of the tree, indexed by node midpoint.
    longint  tree_slope [DOM];
    longint  tree_icpt  [DOM];
    bit      tree_used  [DOM];

    item_t   pending_items [$];
    result_t expected_mins [$];

    int      send_idle_pct;
    int      recv_idle_pct;
    int      hold_req_cnt;
    int      hold_seen_cnt;
    int      hold_left;
    int      mismatch_cnt;
    int      quiet_cycles;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Insert walk: keep the lower line at the midpoint, push the other down.
    function automatic void tree_insert(longint slope, longint icpt);
        longint lo, hi, mid, xm, xl, os, oc, ts;
        lo = 0;
        hi = DOM - 1;
        while (lo <= hi)
        begin
            mid = (lo + hi) >>> 1;
            xm  = mid - HALF;
            xl  = lo - HALF;
            if (!tree_used[mid])
            begin
                tree_slope[mid] = slope;
                tree_icpt[mid]  = icpt;
                tree_used[mid]  = 1'b1;
                return;
            end
            os = tree_slope[mid];
            oc = tree_icpt[mid];
            // ties keep the stored line
            if (slope * xm + icpt < os * xm + oc)
            begin
                tree_slope[mid] = slope;
                tree_icpt[mid]  = icpt;
                ts = slope; slope = os; os = ts;
                ts = icpt;  icpt = oc;  oc = ts;
            end
            if (slope * xl + icpt < os * xl + oc)
                hi = mid - 1;
            else
                lo = mid + 1;
        end
        // loser past a leaf is dropped
    endfunction

    // Minimum over the valid nodes on the path to x.
    function automatic result_t tree_query(longint x);
        longint  u, lo, hi, mid, v, best;
        bit      any;
        result_t r;
        u    = x + HALF;
        if (u < 0)
            u = 0;
        if (u > DOM - 1)
            u = DOM - 1;
        x    = u - HALF;
        lo   = 0;
        hi   = DOM - 1;
        best = 0;
        any  = 1'b0;
        while (lo <= hi)
        begin
            mid = (lo + hi) >>> 1;
            if (tree_used[mid])
            begin
                v = tree_slope[mid] * x + tree_icpt[mid];
                if (!any || v < best)
                    best = v;
                any = 1'b1;
            end
            if (u == mid)
                break;
            if (u < mid)
                hi = mid - 1;
            else
                lo = mid + 1;
        end
        r.min_value = best[MIN_W-1:0];
        r.found     = any;
        return r;
    endfunction

    // Append one item to the pending queue.
    function automatic void queue_item(item_t it);
        pending_items.insert(pending_items.size(), it);
    endfunction

    // Update the tree copy for one accepted transfer; queue a result for a query.
    function automatic void apply_item(item_t it);
        case (it.kind)
            KIND_INSERT: tree_insert(longint'(it.line_slope), longint'(it.line_intercept));
            KIND_QUERY:  expected_mins.insert(expected_mins.size(),
                                              tree_query(longint'(it.query_x)));
            KIND_CLEAR:
                for (int i = 0; i < DOM; i++)
                    tree_used[i] = 1'b0;
            default: ;  // unused code: dropped by the block
        endcase
    endfunction

    function automatic item_t make_item(kind_t k, longint slope, longint icpt, int x);
        item_t it;
        it.kind           = k;
        it.line_slope     = slope[SLOPE_W-1:0];
        it.line_intercept = icpt[ICPT_W-1:0];
        it.query_x        = x[QX_W-1:0];
        return it;
    endfunction

    // Random item: mostly inserts and queries on crossing lines, rare clears.
    function automatic item_t rand_item();
        item_t it;
        int    r;
        r = $urandom_range(0, 199);
        it.line_slope     = $urandom;
        it.line_intercept = ICPT_W'({$urandom, $urandom});
        it.query_x        = QX_W'($urandom);
        if (r < 96)       it.kind = KIND_INSERT;
        else if (r < 194) it.kind = KIND_QUERY;
        else if (r < 196) it.kind = KIND_CLEAR;
        else              it.kind = kind_t'(2'd3);
        // small lines most of the time so that they cross inside the domain
        if ($urandom_range(0, 9) < 8)
        begin
            it.line_slope     = $signed($urandom_range(0, 2000)) - 1000;
            it.line_intercept = ICPT_W'(longint'($urandom_range(0, 200020)) - 100010);
        end
        return it;
    endfunction

    // Driver: hold a stalled transfer, otherwise offer the next pending item or idle.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
        end
        else
        begin
            if (item_valid && !item_stall)
            begin
                apply_item(item);
                void'(pending_items.pop_front());
            end
            if (!(item_valid && item_stall))
            begin
                if (pending_items.size() > 0 &&
                    $urandom_range(0, 99) >= send_idle_pct)
                begin
                    item_valid <= 1'b1;
                    item       <= pending_items[0];
                end
                else
                begin
                    item_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random stall, plus one long hold-off on request.
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left    <= hold_left - 1;
            result_stall <= 1'b1;
        end
        else if (hold_seen_cnt != hold_req_cnt)
        begin
            hold_seen_cnt <= hold_req_cnt;
            hold_left     <= LONG_HOLD;
            result_stall  <= 1'b1;
        end
        else
        begin
            result_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    // Monitor: compare each result transfer with the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_mins.size() == 0)
            begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("unexpected result: min_value=%0d found=%0b",
                             result.min_value, result.found);
            end
            else
            begin
                if (result.min_value !== expected_mins[0].min_value ||
                    result.found !== expected_mins[0].found)
                begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("mismatch: expected min_value=%0d found=%0b, got %0d %0b",
                                 expected_mins[0].min_value, expected_mins[0].found,
                                 result.min_value, result.found);
                end
                void'(expected_mins.pop_front());
            end
        end
    end

    // Watchdog: count cycles without any transfer on either channel.
    always @(posedge clk)
    begin
        if ((item_valid && !item_stall) || (result_valid && !result_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WD_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // Wait until the sender has drained and every expected result has come.
    task automatic drain();
        while (pending_items.size() != 0 || item_valid || expected_mins.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        rst_n         = 1'b0;
        item_valid    = 1'b0;
        item          = '0;
        result_stall  = 1'b0;
        send_idle_pct = 24;
        recv_idle_pct = 53;
        hold_req_cnt  = 0;
        hold_seen_cnt = 0;
        hold_left     = 0;
        mismatch_cnt  = 0;
        quiet_cycles  = 0;
        for (int i = 0; i < DOM; i++)
            tree_used[i] = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty store, extremes, ties, unused code, clear.
        queue_item(make_item(KIND_QUERY, 0, 0, 0));
        queue_item(make_item(KIND_INSERT, 2147483647, 64'sd140737488355327, 0));
        queue_item(make_item(KIND_QUERY, 0, 0, -2048));
        queue_item(make_item(KIND_QUERY, 0, 0, 2047));
        queue_item(make_item(KIND_INSERT, -64'sd2147483648, -64'sd140737488355328, 0));
        queue_item(make_item(KIND_QUERY, 0, 0, -2048));
        queue_item(make_item(KIND_QUERY, 0, 0, 2047));
        queue_item(make_item(KIND_INSERT, -64'sd2147483648, 64'sd140737488355327, 0));
        queue_item(make_item(KIND_INSERT, 2147483647, -64'sd140737488355328, 0));
        queue_item(make_item(KIND_QUERY, 0, 0, 0));
        queue_item(make_item(KIND_CLEAR, -1, -1, -1));
        queue_item(make_item(KIND_QUERY, 0, 0, 5));
        queue_item(make_item(KIND_INSERT, 3, 100010, 0));
        queue_item(make_item(KIND_INSERT, 3, 100010, 0));    // tie with stored line
        queue_item(make_item(KIND_INSERT, -3, -100010, 0));
        queue_item(make_item(KIND_INSERT, 0, 0, 0));
        queue_item(make_item(kind_t'(2'd3), -1, -1, -1));     // unused code
        queue_item(make_item(KIND_QUERY, 0, 0, -1));
        queue_item(make_item(KIND_QUERY, 0, 0, 1));
        queue_item(make_item(KIND_QUERY, 0, 0, 1000));
        queue_item(make_item(KIND_QUERY, 0, 0, -1000));
        for (int i = 0; i < 700; i++)
            queue_item(rand_item());
        drain();

        // Receiver holds off while the sender keeps offering, then swap idle rates.
        send_idle_pct = 53;
        recv_idle_pct = 24;
        hold_req_cnt  = hold_req_cnt + 1;
        for (int i = 0; i < 700; i++)
            queue_item(rand_item());
        drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (int i = 0; i < 600; i++)
            queue_item(rand_item());
        drain();

        repeat (200) @(posedge clk);
        if (mismatch_cnt == 0 && expected_mins.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
